// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/dpms_pkg.sv =====
// ----------------------------------------------------------------------------
// dpms_pkg
// Shared types and constants of the drive PID block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpms_pkg;

  localparam int TICK_MS    = 10;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] MODE_MOVE   = 2'd0;
  localparam logic [1:0] MODE_TURN   = 2'd1;
  localparam logic [1:0] MODE_STRAFE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_POWER_CAP = 3'd3,
    REG_MODE      = 3'd4,
    REG_DIR_NEG   = 3'd5,
    REG_TARGET    = 3'd6,
    REG_TIMEOUT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0]        gain_p;
    logic [11:0]        gain_i;
    logic [11:0]        gain_d;
    logic [6:0]         power_cap;
    logic [1:0]         motion_mode;
    logic               direction_negative;
    logic signed [23:0] target_position;
    logic [15:0]        timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic               ran;
    logic signed [23:0] err;
    logic signed [31:0] err_sum;
    logic signed [24:0] err_diff;
  } stage_t;

endpackage

// ===== design/dpms_cfg.sv =====
// ----------------------------------------------------------------------------
// dpms_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpms_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dpms_pkg::cfg_t                   cfg
);

  dpms_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p             <= 12'd179;
      cfg_r.gain_i             <= 12'd0;
      cfg_r.gain_d             <= 12'd282;
      cfg_r.power_cap          <= 7'd127;
      cfg_r.motion_mode        <= dpms_pkg::MODE_MOVE;
      cfg_r.direction_negative <= 1'b0;
      cfg_r.target_position    <= 24'sd0;
      cfg_r.timeout_ms         <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (dpms_pkg::reg_idx_t'(cfg_index))
        dpms_pkg::REG_GAIN_P:    cfg_r.gain_p             <= cfg_data[11:0];
        dpms_pkg::REG_GAIN_I:    cfg_r.gain_i             <= cfg_data[11:0];
        dpms_pkg::REG_GAIN_D:    cfg_r.gain_d             <= cfg_data[11:0];
        dpms_pkg::REG_POWER_CAP: cfg_r.power_cap          <= cfg_data[6:0];
        dpms_pkg::REG_MODE:      cfg_r.motion_mode        <= cfg_data[1:0];
        dpms_pkg::REG_DIR_NEG:   cfg_r.direction_negative <= cfg_data[0];
        dpms_pkg::REG_TARGET:    cfg_r.target_position    <= signed'(cfg_data[23:0]);
        dpms_pkg::REG_TIMEOUT:   cfg_r.timeout_ms         <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/dpms_err.sv =====
// ----------------------------------------------------------------------------
// dpms_err
// Error stage: baselines, error history, integral, elapsed time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpms_err (
  input  logic               clk,
  input  logic               rst_n,
  input  dpms_pkg::cfg_t     cfg,
  input  logic               in_fire,
  input  logic               in_start_req,
  input  logic signed [23:0] in_left_back_pos,
  input  logic signed [23:0] in_right_back_pos,
  input  logic               s2_take,
  output logic               s1_valid,
  output dpms_pkg::stage_t   s1
);

  logic signed [23:0] left_base_r, right_base_r, prev_err_r;
  logic signed [31:0] err_sum_r;
  logic [16:0]        elapsed_r;
  logic               s1_valid_r;
  dpms_pkg::stage_t   s1_r;

  logic signed [23:0] base_l, base_r, prev_e;
  logic signed [31:0] sum_e;
  logic [16:0]        elapsed_e;
  logic               run;
  logic signed [25:0] off_l, off_r, abs_l, abs_r, measured;
  logic signed [26:0] err_full;
  logic signed [23:0] err;
  logic signed [24:0] diff;
  logic signed [32:0] sum_full;
  logic signed [31:0] sum_sat;
  logic [17:0]        elapsed_sum;
  logic [16:0]        elapsed_nxt;
  logic               s1_valid_nxt;

  always_comb begin
    base_l    = in_start_req ? in_left_back_pos  : left_base_r;
    base_r    = in_start_req ? in_right_back_pos : right_base_r;
    prev_e    = in_start_req ? 24'sd0 : prev_err_r;
    sum_e     = in_start_req ? 32'sd0 : err_sum_r;
    elapsed_e = in_start_req ? 17'd0  : elapsed_r;
    run       = elapsed_e < {1'b0, cfg.timeout_ms};

    off_l = 26'(in_left_back_pos) - 26'(base_l);
    off_r = 26'(in_right_back_pos) - 26'(base_r);
    abs_l = off_l[25] ? -off_l : off_l;
    abs_r = off_r[25] ? -off_r : off_r;
    if (cfg.motion_mode == dpms_pkg::MODE_TURN) begin
      measured = cfg.direction_negative ? abs_r : abs_l;
    end else begin
      measured = off_l;
    end

    err_full = 27'(cfg.target_position) - 27'(measured);
    if (err_full > 27'sd8388607) begin
      err = 24'sh7FFFFF;
    end else if (err_full < -27'sd8388608) begin
      err = 24'sh800000;
    end else begin
      err = err_full[23:0];
    end

    diff     = 25'(err) - 25'(prev_e);
    sum_full = 33'(sum_e) + 33'(err);
    if (sum_full[32] != sum_full[31]) begin
      sum_sat = sum_full[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      sum_sat = sum_full[31:0];
    end

    elapsed_sum = 18'(elapsed_e) + 18'(dpms_pkg::TICK_MS);
    elapsed_nxt = elapsed_sum[17] ? 17'h1FFFF : elapsed_sum[16:0];

    s1_valid_nxt = in_fire ? 1'b1 : (s2_take ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_base_r  <= 24'sd0;
      right_base_r <= 24'sd0;
      prev_err_r   <= 24'sd0;
      err_sum_r    <= 32'sd0;
      elapsed_r    <= 17'd0;
      s1_valid_r   <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        left_base_r  <= base_l;
        right_base_r <= base_r;
        prev_err_r   <= run ? err : prev_e;
        err_sum_r    <= run ? sum_sat : sum_e;
        elapsed_r    <= run ? elapsed_nxt : elapsed_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.ran      <= run;
      s1_r.err      <= run ? err : prev_e;
      s1_r.err_sum  <= sum_sat;
      s1_r.err_diff <= diff;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  `ASSERT_CLK(a_fire_fills, in_fire |=> s1_valid_r, "accepted beat did not reach stage")
  `ASSERT_CLK(a_stage_holds, (s1_valid_r && !s2_take && !in_fire) |=> s1_valid_r,
              "stage beat dropped without transfer")
  `ASSERT_CLK(a_elapsed_frozen, (in_fire && !in_start_req && !run) |=> $stable(elapsed_r),
              "elapsed time moved after timeout")

endmodule

// ===== design/dpms_out.sv =====
// ----------------------------------------------------------------------------
// dpms_out
// Power stage: PID products, scaling, cap, wheel mapping, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpms_out (
  input  logic              clk,
  input  logic              rst_n,
  input  dpms_pkg::cfg_t    cfg,
  input  logic              s1_valid,
  input  dpms_pkg::stage_t  s1,
  output logic              s2_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_left_back_drive,
  output logic signed [7:0] out_left_front_drive,
  output logic signed [7:0] out_right_back_drive,
  output logic signed [7:0] out_right_front_drive,
  output logic              out_active,
  output logic signed [23:0] out_position_error
);

  logic signed [36:0] prod_p;
  logic signed [44:0] prod_i;
  logic signed [37:0] prod_d;
  logic signed [46:0] acc, acc_adj;
  logic signed [38:0] quot;
  logic signed [7:0]  pwr_sat, cap_pos, cap_neg, power, power_neg, drv_pos, drv_neg;
  logic signed [7:0]  lb_nxt, lf_nxt, rb_nxt, rf_nxt;

  logic              out_valid_r, active_r;
  logic signed [7:0] lb_r, lf_r, rb_r, rf_r;
  logic signed [23:0] pos_err_r;

  always_comb begin
    prod_p  = signed'({1'b0, cfg.gain_p}) * s1.err;
    prod_i  = signed'({1'b0, cfg.gain_i}) * s1.err_sum;
    prod_d  = signed'({1'b0, cfg.gain_d}) * s1.err_diff;
    acc     = 47'(prod_p) + 47'(prod_i) + 47'(prod_d);
    acc_adj = acc[46] ? acc + 47'sd255 : acc;
    quot    = acc_adj[46:8];

    if (quot > 39'sd127) begin
      pwr_sat = 8'sd127;
    end else if (quot < -39'sd127) begin
      pwr_sat = -8'sd127;
    end else begin
      pwr_sat = quot[7:0];
    end

    cap_pos = signed'({1'b0, cfg.power_cap});
    cap_neg = -cap_pos;
    power   = pwr_sat;
    if (cfg.motion_mode != dpms_pkg::MODE_TURN) begin
      if (pwr_sat > cap_pos) begin
        power = cap_pos;
      end else if (pwr_sat < cap_neg) begin
        power = cap_neg;
      end
    end

    power_neg = -power;
    drv_pos   = cfg.direction_negative ? power_neg : power;
    drv_neg   = cfg.direction_negative ? power : power_neg;

    case (cfg.motion_mode)
      dpms_pkg::MODE_TURN: begin
        lb_nxt = drv_neg;
        lf_nxt = drv_neg;
        rb_nxt = drv_pos;
        rf_nxt = drv_pos;
      end
      dpms_pkg::MODE_STRAFE: begin
        lb_nxt = drv_neg;
        lf_nxt = drv_pos;
        rb_nxt = drv_pos;
        rf_nxt = drv_neg;
      end
      default: begin
        lb_nxt = drv_pos;
        lf_nxt = drv_pos;
        rb_nxt = drv_pos;
        rf_nxt = drv_pos;
      end
    endcase
  end

  assign s2_take = s1_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lb_r        <= 8'sd0;
      lf_r        <= 8'sd0;
      rb_r        <= 8'sd0;
      rf_r        <= 8'sd0;
    end else begin
      if (s2_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s2_take && s1.ran) begin
        lb_r <= lb_nxt;
        lf_r <= lf_nxt;
        rb_r <= rb_nxt;
        rf_r <= rf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      active_r  <= s1.ran;
      pos_err_r <= s1.err;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_left_back_drive   = lb_r;
  assign out_left_front_drive  = lf_r;
  assign out_right_back_drive  = rb_r;
  assign out_right_front_drive = rf_r;
  assign out_active            = active_r;
  assign out_position_error    = pos_err_r;

  `ASSERT_CLK(a_take_fills, s2_take |=> out_valid_r, "taken beat missing at result")
  `ASSERT_CLK(a_hold_drives, (s2_take && !s1.ran) |=> (lb_r == $past(lb_r) && rf_r == $past(rf_r)),
              "drives changed on an idle tick")
  `ASSERT_CLK(a_drive_range, out_valid_r |-> (lb_r != -8'sd128 && lf_r != -8'sd128 &&
              rb_r != -8'sd128 && rf_r != -8'sd128), "drive outside +-127")

endmodule

// ===== design/drive_pid_move_turn_strafe.sv =====
// ----------------------------------------------------------------------------
// drive_pid_move_turn_strafe
// Tick-driven PID loop for a four-wheel base in move, turn and strafe modes.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    start_req, left_back_pos, right_back_pos
//  out      out_valid / out_stall  four drives, active, position_error
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall is low; each input passes the stage register, then the result register.
//  The error stage and the integral update in the accepting cycle, the three
//  gain products, scaling and wheel mapping in the stage before the result
//  register. Reset is synchronous and clears history, baselines and drives.
//  An output stall backs up through one stage register before in_stall rises.
`timescale 1ns / 1ps

module drive_pid_move_turn_strafe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_start_req,
  input  logic signed [23:0]               in_left_back_pos,
  input  logic signed [23:0]               in_right_back_pos,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [7:0]                out_left_back_drive,
  output logic signed [7:0]                out_left_front_drive,
  output logic signed [7:0]                out_right_back_drive,
  output logic signed [7:0]                out_right_front_drive,
  output logic                             out_active,
  output logic signed [23:0]               out_position_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dpms_pkg::cfg_t   cfg;
  dpms_pkg::stage_t s1;
  logic             s1_valid, s2_take, in_fire;

  assign in_stall = s1_valid && !s2_take;
  assign in_fire  = in_valid && !in_stall;

  dpms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpms_err u_err (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_fire           (in_fire),
    .in_start_req      (in_start_req),
    .in_left_back_pos  (in_left_back_pos),
    .in_right_back_pos (in_right_back_pos),
    .s2_take           (s2_take),
    .s1_valid          (s1_valid),
    .s1                (s1)
  );

  dpms_out u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .s1_valid              (s1_valid),
    .s1                    (s1),
    .s2_take               (s2_take),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_left_back_drive   (out_left_back_drive),
    .out_left_front_drive  (out_left_front_drive),
    .out_right_back_drive  (out_right_back_drive),
    .out_right_front_drive (out_right_front_drive),
    .out_active            (out_active),
    .out_position_error    (out_position_error)
  );

endmodule

// ===== tb/sv/drive_pid_move_turn_strafe_test.sv =====
// ----------------------------------------------------------------------------
// drive_pid_move_turn_strafe_test
// Self-checking bench for the drive PID block: a local PID predictor tracks
// baselines, error history and elapsed time. Directed ticks cover extremes,
// every motion mode, unused mode and timeout corners. Random phases then run
// start-and-settle sequences, windup runs and noise under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_pid_move_turn_strafe_test;

  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [23:0] POS_MAX     = 24'h7FFFFF;
  localparam logic [23:0] POS_MIN     = 24'h800000;
  localparam longint      ERR_HI      = 64'sd8388607;
  localparam longint      ERR_LO      = -ERR_HI - 1;
  localparam longint      SUM_HI      = 64'sd2147483647;
  localparam longint      SUM_LO      = -SUM_HI - 1;
  localparam longint      ELAPSED_TOP = 64'sd131071;
  localparam longint      DRIVE_MAX   = 64'sd127;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          RUN_TICKS   = 1520;

  typedef struct packed {
    logic               start;
    logic signed [23:0] left;
    logic signed [23:0] right;
  } tick_t;

  typedef struct packed {
    logic signed [7:0]  lb;
    logic signed [7:0]  lf;
    logic signed [7:0]  rb;
    logic signed [7:0]  rf;
    logic               active;
    logic signed [23:0] err;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_start_req = 1'b0;
  logic signed [23:0]              in_left_back_pos = '0;
  logic signed [23:0]              in_right_back_pos = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [7:0]               out_left_back_drive;
  logic signed [7:0]               out_left_front_drive;
  logic signed [7:0]               out_right_back_drive;
  logic signed [7:0]               out_right_front_drive;
  logic                            out_active;
  logic signed [23:0]              out_position_error;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dpms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dpms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  drive_pid_move_turn_strafe dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_start_req          (in_start_req),
    .in_left_back_pos      (in_left_back_pos),
    .in_right_back_pos     (in_right_back_pos),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_left_back_drive   (out_left_back_drive),
    .out_left_front_drive  (out_left_front_drive),
    .out_right_back_drive  (out_right_back_drive),
    .out_right_front_drive (out_right_front_drive),
    .out_active            (out_active),
    .out_position_error    (out_position_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  dpms_pkg::cfg_t      cfg_model;
  logic signed [23:0]  base_left = '0;
  logic signed [23:0]  base_right = '0;
  logic signed [23:0]  prev_err = '0;
  logic signed [31:0]  err_sum = '0;
  logic [16:0]         elapsed_ms_q = '0;
  logic signed [7:0]   wheel [4] = '{default: '0};

  tick_t  ticks_pending [$];
  drive_t drive_due [$];
  int     ticks_queued = 0;
  int     drives_seen = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     in_gap = 0;
  int     out_hold = 0;
  logic   in_calm = 1'b0;
  logic   out_calm = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [23:0] pos_sat(longint v);
    return 24'(clip(v, ERR_LO, ERR_HI));
  endfunction

  function automatic int unsigned draw_bits(int w);
    int unsigned top;
    top = (32'd1 << w) - 1;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      2: return 32'd1 << (w - 1);
      3: return (32'd1 << (w - 1)) - 1;
      default: return $urandom & top;
    endcase
  endfunction

  function automatic drive_t pid_tick(logic start, logic signed [23:0] left_pos,
                                      logic signed [23:0] right_pos);
    longint meas, err, diff, acc, pwr, fwd;
    drive_t r;
    if (start) begin
      base_left    = left_pos;
      base_right   = right_pos;
      prev_err     = '0;
      err_sum      = '0;
      elapsed_ms_q = '0;
    end
    r.active = 1'b0;
    if (elapsed_ms_q < cfg_model.timeout_ms) begin
      if (cfg_model.motion_mode == dpms_pkg::MODE_TURN)
        meas = cfg_model.direction_negative ?
               mag(longint'(right_pos) - longint'(base_right)) :
               mag(longint'(left_pos) - longint'(base_left));
      else
        meas = longint'(left_pos) - longint'(base_left);
      err = clip(longint'(cfg_model.target_position) - meas, ERR_LO, ERR_HI);
      diff = err - longint'(prev_err);
      err_sum = 32'(clip(longint'(err_sum) + err, SUM_LO, SUM_HI));
      prev_err = 24'(err);
      acc = longint'(cfg_model.gain_p) * err + longint'(cfg_model.gain_i) * longint'(err_sum)
          + longint'(cfg_model.gain_d) * diff;
      pwr = clip(acc / 256, -DRIVE_MAX, DRIVE_MAX);
      if (cfg_model.motion_mode != dpms_pkg::MODE_TURN)
        pwr = clip(pwr, -longint'(cfg_model.power_cap), longint'(cfg_model.power_cap));
      fwd = cfg_model.direction_negative ? -pwr : pwr;
      case (cfg_model.motion_mode)
        dpms_pkg::MODE_TURN: begin
          wheel[0] = 8'(-fwd); wheel[1] = 8'(-fwd); wheel[2] = 8'(fwd); wheel[3] = 8'(fwd);
        end
        dpms_pkg::MODE_STRAFE: begin
          wheel[0] = 8'(-fwd); wheel[1] = 8'(fwd); wheel[2] = 8'(fwd); wheel[3] = 8'(-fwd);
        end
        default: begin
          wheel[0] = 8'(fwd); wheel[1] = 8'(fwd); wheel[2] = 8'(fwd); wheel[3] = 8'(fwd);
        end
      endcase
      elapsed_ms_q = 17'(clip(longint'(elapsed_ms_q) + dpms_pkg::TICK_MS, 0, ELAPSED_TOP));
      r.active = 1'b1;
    end
    r.lb  = wheel[0];
    r.lf  = wheel[1];
    r.rb  = wheel[2];
    r.rf  = wheel[3];
    r.err = prev_err;
    return r;
  endfunction

  task automatic log_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic add_tick(logic start, logic [23:0] left_pos, logic [23:0] right_pos);
    tick_t t;
    t.start = start;
    t.left  = left_pos;
    t.right = right_pos;
    ticks_pending.push_back(t);
    ticks_queued++;
  endtask

  task automatic set_reg(dpms_pkg::reg_idx_t idx, logic [dpms_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dpms_pkg::REG_GAIN_P:    cfg_model.gain_p = val[11:0];
      dpms_pkg::REG_GAIN_I:    cfg_model.gain_i = val[11:0];
      dpms_pkg::REG_GAIN_D:    cfg_model.gain_d = val[11:0];
      dpms_pkg::REG_POWER_CAP: cfg_model.power_cap = val[6:0];
      dpms_pkg::REG_MODE:      cfg_model.motion_mode = val[1:0];
      dpms_pkg::REG_DIR_NEG:   cfg_model.direction_negative = val[0];
      dpms_pkg::REG_TARGET:    cfg_model.target_position = val[23:0];
      dpms_pkg::REG_TIMEOUT:   cfg_model.timeout_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (drives_seen < ticks_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall)
        drive_due.push_back(pid_tick(in_start_req, in_left_back_pos, in_right_back_pos));
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (ticks_pending.size() > 0) begin
        nxt = ticks_pending.pop_front();
        in_valid          <= 1'b1;
        in_start_req      <= nxt.start;
        in_left_back_pos  <= nxt.left;
        in_right_back_pos <= nxt.right;
        in_gap            <= in_calm ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0)
          in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    drive_t got, want;
    int     hold_n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      hold_n = out_hold;
      if (out_valid && !out_stall) begin
        drives_seen++;
        got.lb     = out_left_back_drive;
        got.lf     = out_left_front_drive;
        got.rb     = out_right_back_drive;
        got.rf     = out_right_front_drive;
        got.active = out_active;
        got.err    = out_position_error;
        if (drive_due.size() == 0) begin
          log_mismatch("result beat with no tick outstanding");
        end else begin
          want = drive_due.pop_front();
          if (got.lb !== want.lb)
            log_mismatch($sformatf("left_back_drive %0d, want %0d", got.lb, want.lb));
          if (got.lf !== want.lf)
            log_mismatch($sformatf("left_front_drive %0d, want %0d", got.lf, want.lf));
          if (got.rb !== want.rb)
            log_mismatch($sformatf("right_back_drive %0d, want %0d", got.rb, want.rb));
          if (got.rf !== want.rf)
            log_mismatch($sformatf("right_front_drive %0d, want %0d", got.rf, want.rf));
          if (got.active !== want.active)
            log_mismatch($sformatf("active %0b, want %0b", got.active, want.active));
          if (got.err !== want.err)
            log_mismatch($sformatf("position_error %0d, want %0d", got.err, want.err));
        end
        hold_n = out_calm ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0)
          out_calm <= !out_calm;
      end
      if (hold_n > 0) begin
        out_stall <= 1'b1;
        out_hold  <= hold_n - 1;
      end else begin
        out_stall <= 1'b0;
        out_hold  <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("drive_pid_move_turn_strafe regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          n, kind, tgt, k;
    longint      off, roff, left0, right0;
    logic [23:0] bits;

    cfg_model.gain_p             = 12'd179;
    cfg_model.gain_i             = 12'd0;
    cfg_model.gain_d             = 12'd282;
    cfg_model.power_cap          = 7'd127;
    cfg_model.motion_mode        = dpms_pkg::MODE_MOVE;
    cfg_model.direction_negative = 1'b0;
    cfg_model.target_position    = '0;
    cfg_model.timeout_ms         = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero timeout, loop never runs
    add_tick(1'b0, POS_MAX, POS_MIN);
    add_tick(1'b1, POS_MIN, POS_MAX);
    add_tick(1'b0, 24'd5, 24'd5);
    drain_all();

    set_reg(dpms_pkg::REG_GAIN_P, 24'd256);
    set_reg(dpms_pkg::REG_GAIN_I, 24'd0);
    set_reg(dpms_pkg::REG_GAIN_D, 24'd0);
    set_reg(dpms_pkg::REG_POWER_CAP, 24'd50);
    set_reg(dpms_pkg::REG_MODE, 24'(dpms_pkg::MODE_MOVE));
    set_reg(dpms_pkg::REG_DIR_NEG, 24'd0);
    set_reg(dpms_pkg::REG_TARGET, 24'd1000);
    set_reg(dpms_pkg::REG_TIMEOUT, 24'd35);
    // no start yet: baselines stay zero, then the run expires
    add_tick(1'b0, 24'd200, 24'd7);
    add_tick(1'b0, POS_MAX, 24'd0);
    add_tick(1'b0, POS_MIN, 24'd0);
    add_tick(1'b0, 24'd900, 24'd0);
    add_tick(1'b0, 24'd0, 24'd0);
    add_tick(1'b1, POS_MIN, POS_MAX);
    add_tick(1'b0, POS_MAX, POS_MIN);
    drain_all();

    set_reg(dpms_pkg::REG_GAIN_P, 24'd4095);
    set_reg(dpms_pkg::REG_GAIN_I, 24'd4095);
    set_reg(dpms_pkg::REG_GAIN_D, 24'd4095);
    set_reg(dpms_pkg::REG_MODE, 24'(dpms_pkg::MODE_TURN));
    set_reg(dpms_pkg::REG_DIR_NEG, 24'd1);
    set_reg(dpms_pkg::REG_TARGET, POS_MIN);
    set_reg(dpms_pkg::REG_TIMEOUT, 24'hFFFF);
    add_tick(1'b1, 24'd0, POS_MAX);
    add_tick(1'b0, 24'd0, POS_MIN);
    add_tick(1'b0, POS_MIN, POS_MAX);
    drain_all();

    set_reg(dpms_pkg::REG_MODE, 24'(dpms_pkg::MODE_STRAFE));
    set_reg(dpms_pkg::REG_DIR_NEG, 24'd0);
    set_reg(dpms_pkg::REG_POWER_CAP, 24'd127);
    set_reg(dpms_pkg::REG_TARGET, POS_MAX);
    set_reg(dpms_pkg::REG_GAIN_P, 24'd179);
    set_reg(dpms_pkg::REG_GAIN_I, 24'd0);
    set_reg(dpms_pkg::REG_GAIN_D, 24'd282);
    add_tick(1'b1, 24'd10, 24'd20);
    add_tick(1'b0, 24'd500, 24'd0);
    drain_all();

    set_reg(dpms_pkg::REG_MODE, 24'(MODE_SPARE));
    set_reg(dpms_pkg::REG_DIR_NEG, 24'd1);
    set_reg(dpms_pkg::REG_POWER_CAP, 24'd0);
    add_tick(1'b1, 24'd0, 24'd0);
    add_tick(1'b0, 24'hFFFF00, 24'd0);
    drain_all();

    set_reg(dpms_pkg::REG_TIMEOUT, 24'd0);
    add_tick(1'b1, 24'd3, 24'd4);
    add_tick(1'b0, 24'd9, 24'd0);
    drain_all();

    set_reg(dpms_pkg::REG_TIMEOUT, 24'd10);
    set_reg(dpms_pkg::REG_MODE, 24'(dpms_pkg::MODE_TURN));
    set_reg(dpms_pkg::REG_DIR_NEG, 24'd0);
    set_reg(dpms_pkg::REG_POWER_CAP, 24'd127);
    add_tick(1'b1, 24'd0, 24'd0);
    add_tick(1'b0, -24'sd300, 24'd0);
    add_tick(1'b0, 24'd0, 24'd0);

    while (ticks_queued < RUN_TICKS) begin
      drain_all();
      kind = $urandom_range(0, 24);
      n = $urandom_range(5, 60);
      if (kind == 0) begin
        n = 270;
        set_reg(dpms_pkg::REG_GAIN_I, 24'($urandom_range(1, 4095)));
        set_reg(dpms_pkg::REG_MODE, 24'($urandom_range(0, 3)));
        set_reg(dpms_pkg::REG_TARGET, $urandom_range(0, 1) ? POS_MAX : POS_MIN);
        set_reg(dpms_pkg::REG_TIMEOUT, 24'hFFFF);
      end else begin
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_GAIN_P,
                  24'($urandom_range(0, 3) ? $urandom_range(0, 600) : draw_bits(12)));
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_GAIN_I,
                  24'($urandom_range(0, 2) ? $urandom_range(0, 16) : draw_bits(12)));
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_GAIN_D,
                  24'($urandom_range(0, 3) ? $urandom_range(0, 600) : draw_bits(12)));
        if ($urandom_range(0, 2) == 0)
          set_reg(dpms_pkg::REG_POWER_CAP, 24'(draw_bits(7)));
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_MODE, 24'($urandom_range(0, 3)));
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_DIR_NEG, 24'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
          set_reg(dpms_pkg::REG_TARGET, 24'($urandom_range(0, 4) ?
                  int'($urandom_range(0, 8000)) - 4000 : draw_bits(24)));
        set_reg(dpms_pkg::REG_TIMEOUT, 24'($urandom_range(0, 5) ?
                $urandom_range(0, (n + 3) * 10) : draw_bits(16)));
      end
      tgt = int'(cfg_model.target_position);

      if (kind == 0) begin
        // hold far from target so the error sum winds up to its limit
        add_tick(1'b1, 24'd0, 24'd0);
        for (k = 0; k < n; k++)
          add_tick(1'b0, (tgt > 0) ? POS_MIN : POS_MAX, (tgt > 0) ? POS_MAX : POS_MIN);
      end else if (kind <= 20) begin
        bits = 24'(draw_bits(24));
        left0 = longint'($signed(bits));
        bits = 24'(draw_bits(24));
        right0 = longint'($signed(bits));
        add_tick(1'b1, pos_sat(left0), pos_sat(right0));
        off = 0;
        roff = 0;
        for (k = 0; k < n; k++) begin
          off  = off + (tgt - off) / 3 + int'($urandom_range(0, 300)) - 150;
          roff = roff + (-tgt - roff) / 3 + int'($urandom_range(0, 300)) - 150;
          add_tick($urandom_range(0, 39) == 0, pos_sat(left0 + off), pos_sat(right0 + roff));
        end
      end else begin
        for (k = 0; k < n; k++)
          add_tick($urandom_range(0, 5) == 0, 24'(draw_bits(24)), 24'(draw_bits(24)));
      end
    end

    drain_all();
    repeat (10) @(posedge clk);
    while (drive_due.size() > 0) begin
      void'(drive_due.pop_front());
      log_mismatch("tick never produced a result");
    end
    if (mismatches == 0)
      $display("drive_pid_move_turn_strafe regression: pass");
    else
      $display("drive_pid_move_turn_strafe regression: fail");
    $finish;
  end

endmodule
